[rtl/fdd_pkg.sv]
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and constants of the fingerprint difference decoder
// Widths of the data path, step count of the serial reduction and the
// control group that drives the row of bit-slice cells.
// ----------------------------------------------------------------------------
package fdd_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned PrevW  = WordW - 1;
  // bits of prev followed by one zero bit per word bit
  localparam int unsigned Steps  = PrevW + WordW;
  localparam int unsigned CntW   = $clog2(Steps);

  // control group from the sequencer to the cell row
  typedef struct packed {
    logic clear;     // zero the remainder
    logic shift;     // one shift-and-subtract step
    logic mod_load;  // take a new modulus
  } fdd_step_t;

endpackage

[rtl/fingerprint_difference_decoder.sv]
// ----------------------------------------------------------------------------
// fingerprint_difference_decoder: rebuilds text blocks from prefix fingerprints
// Serial modular reduction over a row of bit-slice cells plus a short
// correction sequence.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries 64-bit fingerprint words; tuser marks the header word that
//   sets the modulus (word + 2^63) and the first previous fingerprint, tlast
//   marks the final word of the stream and is copied to the result.
//   m_axis carries one rebuilt block per data word; tuser flags a zero
//   modulus, in which case the block is zero.
// sequence
//   a header word is taken in the idle state and gives no result.
//   a data word runs 127 reduction steps through the cell row (63 bits of
//   the previous fingerprint, then 64 zero bits), then the correction steps
//   (subtract, add the modulus, add it again for a set top bit) and an
//   output step that waits for a free output register; the next word is
//   taken only after the output step. a zero modulus skips the reduction
//   and the corrections and goes straight to the output step.
// reset and stall
//   reset clears the modulus and the previous fingerprint to zero, so data
//   before any header gives flagged zero results. the result sits in an
//   output register; the next word is taken while it waits, and the block
//   only holds its new result back when that register is still full.
// ----------------------------------------------------------------------------
module fingerprint_difference_decoder
  import fdd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [WordW-1:0] s_axis_tdata_i,   // [63:0] word
  input  logic             s_axis_tlast_i,
  input  logic             s_axis_tuser_i,   // [0] is_first
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [WordW-1:0] m_axis_tdata_o,   // [63:0] block
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o    // [0] modulus_error
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StCalc = 6'b000010,
    StSubP = 6'b000100,
    StAddM = 6'b001000,
    StAddT = 6'b010000,
    StEmit = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PrevW-1:0] prev_q, prev_d;
  logic [PrevW-1:0] hi_q, hi_d;
  logic [WordW-1:0] p_q, p_d;
  logic             last_q, last_d;
  logic             err_q, err_d;
  logic             gt_q, gt_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_data_q, out_data_d;
  logic             out_last_q, out_last_d;
  logic             out_err_q, out_err_d;

  fdd_step_t        step;
  logic [WordW-1:0] rem;
  logic [WordW-1:0] modulus;
  logic [WordW-1:0] mod_word;
  logic             in_xfer;
  logic             out_xfer;
  logic             mod_zero;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_xfer        = out_valid_q & m_axis_tready_i;
  assign mod_zero        = (modulus == '0);
  // word + 2^63 wraps to a flip of the top bit
  assign mod_word        = {~s_axis_tdata_i[WordW-1], s_axis_tdata_i[WordW-2:0]};

  fdd_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .mod_word_i (mod_word),
    .serial_i   (hi_q[PrevW-1]),
    .rem_o      (rem),
    .mod_o      (modulus)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    hi_d        = hi_q;
    p_d         = p_q;
    last_d      = last_q;
    err_d       = err_q;
    gt_d        = gt_q;
    acc_d       = acc_q;
    step        = '0;
    out_valid_d = out_valid_q & ~out_xfer;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          prev_d = s_axis_tdata_i[PrevW-1:0];
          if (s_axis_tuser_i) begin
            step.mod_load = 1'b1;
          end else begin
            p_d    = s_axis_tdata_i;
            last_d = s_axis_tlast_i;
            hi_d   = prev_q;
            cnt_d  = '0;
            if (mod_zero) begin
              err_d   = 1'b1;
              acc_d   = '0;
              state_d = StEmit;
            end else begin
              err_d      = 1'b0;
              step.clear = 1'b1;
              state_d    = StCalc;
            end
          end
        end
      end
      StCalc: begin
        step.shift = 1'b1;
        hi_d       = {hi_q[PrevW-2:0], 1'b0};
        cnt_d      = cnt_q + CntW'(1);
        if (cnt_q == CntW'(Steps - 1)) begin
          cnt_d   = '0;
          state_d = StSubP;
        end
      end
      StSubP: begin
        // borrow out says the remainder exceeds the word
        {gt_d, acc_d} = {1'b0, p_q} - {1'b0, rem};
        state_d       = StAddM;
      end
      StAddM: begin
        acc_d   = acc_q + (gt_q ? modulus : '0);
        state_d = StAddT;
      end
      StAddT: begin
        acc_d   = acc_q + (p_q[WordW-1] ? modulus : '0);
        state_d = StEmit;
      end
      StEmit: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          out_last_d  = last_q;
          out_err_d   = err_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q       <= hi_d;
    p_q        <= p_d;
    last_q     <= last_d;
    err_q      <= err_d;
    gt_q       <= gt_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_err_q;

`ifndef SYNTHESIS
  // the remainder stays reduced below the modulus through the whole reduction
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCalc || state_q == StSubP) |-> (rem < modulus))
    else $error("remainder not below modulus");

  // the step counter only runs during the reduction
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StCalc) |-> (cnt_q == '0))
    else $error("step counter running outside reduction");

  // a flagged result always carries a zero block
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("flagged result with nonzero block");

  // a header transfer reloads the modulus and raises no result
  a_header_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser_i) |=>
      (modulus == $past(mod_word)) && (state_q == StIdle)
      && (out_valid_q == $past(out_valid_d)))
    else $error("header transfer mishandled");
`endif

endmodule

[rtl/fdd_cell.sv]
// ----------------------------------------------------------------------------
// fdd_cell: one bit slice of the serial modular reducer
// Holds one remainder bit and one modulus bit, takes the shifted-in bit from
// its lower neighbor and ripples the borrow of (shifted - modulus) upward.
// ----------------------------------------------------------------------------
module fdd_cell
  import fdd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fdd_step_t step_i,
  input  logic      sub_i,       // row decision: take the difference
  input  logic      mod_bit_i,   // modulus bit to load
  input  logic      shift_in_i,  // remainder bit of the lower neighbor
  input  logic      borrow_i,
  output logic      borrow_o,
  output logic      rem_o,
  output logic      mod_o
);

  logic rem_q, rem_d;
  logic mod_q, mod_d;
  logic diff;

  assign diff     = shift_in_i ^ mod_q ^ borrow_i;
  assign borrow_o = (~shift_in_i & mod_q) | (~(shift_in_i ^ mod_q) & borrow_i);

  always_comb begin
    rem_d = rem_q;
    if (step_i.clear) begin
      rem_d = 1'b0;
    end else if (step_i.shift) begin
      rem_d = sub_i ? diff : shift_in_i;
    end
    mod_d = step_i.mod_load ? mod_bit_i : mod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 1'b0;
      mod_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      mod_q <= mod_d;
    end
  end

  assign rem_o = rem_q;
  assign mod_o = mod_q;

endmodule

[rtl/fdd_chain.sv]
// ----------------------------------------------------------------------------
// fdd_chain: row of bit-slice cells forming a shift-and-subtract reducer
// Each step shifts the remainder up one place, brings in one serial bit and
// subtracts the modulus when the shifted value overflows or reaches it.
// ----------------------------------------------------------------------------
module fdd_chain
  import fdd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fdd_step_t        step_i,
  input  logic [WordW-1:0] mod_word_i,
  input  logic             serial_i,
  output logic [WordW-1:0] rem_o,
  output logic [WordW-1:0] mod_o
);

  logic [WordW:0]   borrow;
  logic [WordW-1:0] shift_in;
  logic             sub;

  assign borrow[0] = 1'b0;
  assign shift_in  = {rem_o[WordW-2:0], serial_i};
  // overflow out of the top cell, or no borrow means shifted >= modulus
  assign sub       = rem_o[WordW-1] | ~borrow[WordW];

  for (genvar i = 0; i < WordW; i++) begin : g_cell
    fdd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step_i),
      .sub_i      (sub),
      .mod_bit_i  (mod_word_i[i]),
      .shift_in_i (shift_in[i]),
      .borrow_i   (borrow[i]),
      .borrow_o   (borrow[i+1]),
      .rem_o      (rem_o[i]),
      .mod_o      (mod_o[i])
    );
  end

endmodule

[dv/fingerprint_difference_decoder_test.sv]
// ----------------------------------------------------------------------------
// fingerprint_difference_decoder_test: self-checking bench of the decoder
// Feeds header and data words over the input stream, rebuilds every block
// with a behavioral model of the modular reduction and compares each output
// transfer field by field. A short table of hand-picked words runs first,
// then random header/data sequences under bursty input and output stalls.
// ----------------------------------------------------------------------------
module fingerprint_difference_decoder_test;
  import fdd_pkg::*;

  localparam logic [WordW-1:0] TopBit = {1'b1, {PrevW{1'b0}}};
  localparam int unsigned RandItems  = 1500;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned DrainCyc   = 200;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             is_first;
    logic             is_last;
  } fp_word_t;

  typedef struct packed {
    logic [WordW-1:0] blk;
    logic             last;
    logic             mod_err;
  } text_block_t;

  typedef struct packed {
    fp_word_t    in;
    logic        typed;
    text_block_t want;
  } stim_row_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [WordW-1:0] s_axis_tdata_i  = '0;   // [63:0] word
  logic             s_axis_tlast_i  = 1'b0;
  logic             s_axis_tuser_i  = 1'b0; // [0] is_first
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [WordW-1:0] m_axis_tdata_o;         // [63:0] block
  logic             m_axis_tlast_o;
  logic             m_axis_tuser_o;         // [0] modulus_error

  fingerprint_difference_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // model state
  logic [WordW-1:0] model_modulus = '0;
  logic [PrevW-1:0] model_prev    = '0;

  text_block_t pending_blocks [$];
  stim_row_t   stim_table [$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // updates the model state and returns 1 when the word yields a block
  function automatic bit rebuild_block(input fp_word_t w, output text_block_t b);
    logic [2*WordW-1:0] wide;
    logic [WordW-1:0]   rem;
    logic [WordW-1:0]   y;
    b = '0;
    if (w.is_first) begin
      model_modulus = w.word + TopBit;
      model_prev    = w.word[PrevW-1:0];
      return 1'b0;
    end
    b.last = w.is_last;
    if (model_modulus == '0) begin
      b.mod_err = 1'b1;
    end else begin
      // (prev * 2^64) mod modulus
      wide = {1'b0, model_prev, {WordW{1'b0}}} % {{WordW{1'b0}}, model_modulus};
      rem  = wide[WordW-1:0];
      y    = (rem <= w.word) ? w.word - rem : model_modulus - (rem - w.word);
      if (w.word[WordW-1]) begin
        y = y + model_modulus;
      end
      b.blk = y;
    end
    model_prev = w.word[PrevW-1:0];
    return 1'b1;
  endfunction

  function automatic logic [WordW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // data word biased toward zero, the top bit and the edges of the current modulus
  function automatic logic [WordW-1:0] pick_data(input logic [WordW-1:0] m);
    case ($urandom_range(0, 5))
      0:       return WordW'($urandom_range(0, 15));
      1:       return m - WordW'($urandom_range(0, 15));
      2:       return m + WordW'($urandom_range(0, 15));
      3:       return TopBit | WordW'($urandom_range(0, 15));
      default: return rand64();
    endcase
  endfunction

  task automatic add_row(input logic [WordW-1:0] word, input logic first, input logic last,
                         input logic typed, input logic [WordW-1:0] blk, input logic err);
    stim_row_t r;
    r.in   = '{word: word, is_first: first, is_last: last};
    r.typed = typed;
    r.want = '{blk: blk, last: last, mod_err: err};
    stim_table.push_back(r);
  endtask

  // called at a rising edge; returns at the edge of the transfer or after the gap
  task automatic send_word(input fp_word_t w, input logic typed, input text_block_t want);
    text_block_t b;
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w.word;
    s_axis_tuser_i  <= w.is_first;
    s_axis_tlast_i  <= w.is_last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    words_sent++;
    if (rebuild_block(w, b)) begin
      pending_blocks.push_back(typed ? want : b);
    end
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    gap = $urandom_range(1, 8);
        2:       gap = $urandom_range(9, 200);
        default: gap = 0;
      endcase
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic report(input string what, input text_block_t want, input text_block_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%s: expected block %h last %b err %b, got block %h last %b err %b",
               what, want.blk, want.last, want.mod_err, got.blk, got.last, got.mod_err);
    end
  endtask

  // output checker
  always @(posedge clk_i) begin
    text_block_t got;
    text_block_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{blk: m_axis_tdata_o, last: m_axis_tlast_o, mod_err: m_axis_tuser_o};
      if (pending_blocks.size() == 0) begin
        report("unexpected block", '0, got);
      end else begin
        want = pending_blocks.pop_front();
        if (got !== want) begin
          report("block mismatch", want, got);
        end
      end
    end
  end

  // receiver stalls: the mode switches between no stalls, short stalls and long stalls
  int unsigned rx_mode  = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_stall = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 1024 == 0) begin
      rx_mode = $urandom_range(0, 2);
    end
    if (rx_stall != 0) begin
      rx_stall--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (rx_mode == 1 && $urandom_range(0, 4) == 0) begin
        rx_stall = $urandom_range(1, 4);
      end else if (rx_mode == 2 && $urandom_range(0, 99) == 0) begin
        rx_stall = $urandom_range(20, 300);
      end
    end
  end

  // watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout with %0d blocks outstanding", pending_blocks.size());
      $display("fingerprint_difference_decoder_test failed");
      $finish;
    end
  end

  initial begin
    logic [WordW-1:0] m;
    fp_word_t         w;
    int unsigned      n;
    bit               paused;
    paused = 1'b0;

    // word, first, last, typed, block, error
    add_row(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 1'b1, '0, 1'b1); // data before any header
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, '0, 1'b1);
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, '0, 1'b0); // header: zero modulus
    add_row(64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b1, '0, 1'b1);
    add_row(64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0, '0, 1'b0); // header with last set
    add_row(64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b1, '0, 1'b0); // prev zero: block is word
    add_row(64'h8000_0000_0000_0005, 1'b0, 1'b0, 1'b1, 64'd5, 1'b0);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, '0, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, '0, 1'b0);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, '0, 1'b0); // largest modulus
    add_row(64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b0, '0, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, '0, 1'b0);
    add_row(64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0, '0, 1'b0);
    add_row(64'h8000_0000_0000_0001, 1'b1, 1'b0, 1'b0, '0, 1'b0); // modulus one
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b1, '0, 1'b0);
    add_row(64'h0000_0000_0000_1234, 1'b0, 1'b0, 1'b1, 64'h1234, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, '0, 1'b0); // prev equals modulus
    add_row(64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 1'b0, '0, 1'b0);
    add_row(64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0, '0, 1'b0);
    add_row(64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0, '0, 1'b0);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0, '0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      send_word(stim_table[i].in, stim_table[i].typed, stim_table[i].want);
    end

    while (words_sent < stim_table.size() + RandItems) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 19))
          0:       m = '0;
          1, 2:    m = WordW'($urandom_range(1, 20));
          3:       m = '1 - WordW'($urandom_range(0, 20));
          4:       m = TopBit + WordW'($urandom_range(0, 20));
          default: m = rand64();
        endcase
        w = '{word: m ^ TopBit, is_first: 1'b1, is_last: ($urandom_range(0, 19) == 0)};
        send_word(w, 1'b0, '0);
        n = $urandom_range(1, 12);
        for (int unsigned k = 0; k < n; k++) begin
          w = '{word: pick_data(m), is_first: 1'b0,
                is_last: (k == n - 1) && $urandom_range(0, 1)};
          send_word(w, 1'b0, '0);
        end
      end else begin
        // noise: any word with random flags
        w = '{word: rand64(), is_first: ($urandom_range(0, 3) == 0),
              is_last: $urandom_range(0, 1)};
        send_word(w, 1'b0, '0);
      end
      if (!paused && words_sent > stim_table.size() + RandItems / 2) begin
        // let the decoder drain completely once
        paused = 1'b1;
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_blocks.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (pending_blocks.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("fingerprint_difference_decoder_test passed");
    end else begin
      $display("fingerprint_difference_decoder_test failed");
    end
    $finish;
  end

endmodule
